// ----- rtl/core/lfpd_pkg.sv -----
// lfpd_pkg: shared types and constants of the line follow pid detour unit
// used by lfpd_ctrl, lfpd_dpath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

   // behavior modes
   localparam logic [3:0] MODE_FOLLOW   = 4'd0;
   localparam logic [3:0] MODE_STOPPING = 4'd1;
   localparam logic [3:0] MODE_TURN_R   = 4'd2;
   localparam logic [3:0] MODE_CHECK_R  = 4'd3;
   localparam logic [3:0] MODE_FWD_SH   = 4'd4;
   localparam logic [3:0] MODE_CHECK_L  = 4'd5;
   localparam logic [3:0] MODE_ALIGN    = 4'd6;
   localparam logic [3:0] MODE_FWD      = 4'd7;
   localparam logic [3:0] MODE_TURN_L   = 4'd8;
   localparam logic [3:0] MODE_FWD_MORE = 4'd9;
   localparam logic [3:0] MODE_FIND     = 4'd10;

   // register indexes
   localparam logic [2:0] REG_KP    = 3'd0;
   localparam logic [2:0] REG_KI    = 3'd1;
   localparam logic [2:0] REG_KD    = 3'd2;
   localparam logic [2:0] REG_BASE  = 3'd3;
   localparam logic [2:0] REG_FRONT = 3'd4;
   localparam logic [2:0] REG_SIDE  = 3'd5;
   localparam logic [2:0] REG_TURN  = 3'd6;
   localparam logic [2:0] REG_AVOID = 3'd7;

   localparam logic [20:0] STOP_HOLD  = 21'd50000;
   localparam logic [20:0] PAUSE_HOLD = 21'd500000;
   localparam logic [20:0] SHORT_HOLD = 21'd1500000;
   localparam logic [20:0] FWD_HOLD   = 21'd1800000;
   localparam logic [20:0] MORE_HOLD  = 21'd2000000;
   localparam logic signed [7:0] TURN_SPD = 8'sd15;
   localparam logic signed [7:0] FIND_SPD = 8'sd7;

   // datapath commands from the controller
   typedef struct packed {
      logic load;      // capture input item
      logic pid_step;  // advance the pid sequence one step
      logic pid_start; // begin the pid sequence
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic pid_done;
      logic no_line;
   } stat_type;

   // one result item
   typedef struct packed {
      logic              drive;
      logic signed [7:0] spd_l;
      logic signed [7:0] spd_r;
      logic [20:0]       hold_us;
   } res_type;

endpackage

`default_nettype wire

// ----- rtl/core/lfpd_dpath.sv -----
// lfpd_dpath: pid datapath; error by shift-subtract division, serial gain products
// depends on lfpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfpd_dpath #(
   parameter int FRAC_BITS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire lfpd_pkg::cmd_type cmd,
   output lfpd_pkg::stat_type   stat,
   input  wire [4:0]            line_bits,
   input  wire [7:0]            kp_gain,
   input  wire [7:0]            ki_gain,
   input  wire [7:0]            kd_gain,
   input  wire [6:0]            cruise_spd,
   output logic signed [7:0]    pid_left,
   output logic signed [7:0]    pid_right
);

   localparam int EW = FRAC_BITS + 3;       // error magnitude bits + sign
   localparam int SW = FRAC_BITS + 8;       // clamp range +-100<<F
   localparam int CW = SW + 12;             // control accumulator
   localparam int NW = FRAC_BITS + 4;       // dividend bits
   localparam int DW = $clog2(NW);          // division step counter bits
   localparam logic signed [SW-1:0] LIM = SW'(100) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] LIMC = CW'(100) <<< FRAC_BITS;

   // sequence steps
   localparam logic [2:0] S_DIV = 3'd0;
   localparam logic [2:0] S_SUM = 3'd1;
   localparam logic [2:0] S_KP  = 3'd2;
   localparam logic [2:0] S_KI  = 3'd3;
   localparam logic [2:0] S_KD  = 3'd4;
   localparam logic [2:0] S_OUT = 3'd5;
   localparam logic [2:0] S_FIN = 3'd6;

   logic [2:0] step_ff, step_in;
   logic [DW-1:0] dcnt_ff, dcnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [2:0] rem_ff, rem_in;
   logic [2:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic signed [EW-1:0] prev_ff, prev_in, err_ff, err_in;
   logic signed [SW-1:0] esum_ff, esum_in;
   logic signed [CW-1:0] acc_ff, acc_in;
   logic signed [7:0] pl_ff, pl_in, pr_ff, pr_in;

   // line weight sum and count
   logic signed [3:0] wsum;
   logic [2:0] cnt;
   logic [2:0] wmag;
   always_comb begin
      wsum = 4'sd0;
      cnt  = 3'd0;
      if (line_bits[0]) wsum = wsum - 4'sd3;
      if (line_bits[1]) wsum = wsum - 4'sd2;
      if (line_bits[3]) wsum = wsum + 4'sd2;
      if (line_bits[4]) wsum = wsum + 4'sd3;
      for (int i = 0; i < 5; i++) cnt = cnt + 3'(line_bits[i]);
      wmag = wsum[3] ? 3'(-wsum) : 3'(wsum);
   end

   logic [3:0] rtry;
   logic signed [SW:0] esum_raw;
   logic signed [CW-1:0] prod, ctrl;
   logic signed [SW+1:0] base_q, lq, rq;
   logic signed [EW:0] derr;

   function automatic logic signed [7:0] to_spd(input logic signed [SW+1:0] q);
      logic [SW+1:0] m;
      logic [SW+1:0] s;
      begin
         m = q[SW+1] ? (SW+2)'(-q) : (SW+2)'(q);
         s = m >> FRAC_BITS;
         if (s > (SW+2)'(100)) s = (SW+2)'(100);
         to_spd = q[SW+1] ? -8'(s) : 8'(s);
      end
   endfunction

   always_comb begin
      step_in = step_ff; dcnt_in = dcnt_ff; quo_in = quo_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; prev_in = prev_ff; err_in = err_ff;
      esum_in = esum_ff; acc_in = acc_ff; pl_in = pl_ff; pr_in = pr_ff;
      rtry = {rem_ff, quo_ff[NW-1]};
      esum_raw = (SW+1)'(esum_ff) + (SW+1)'(err_ff);
      derr = (EW+1)'(err_ff) - (EW+1)'(prev_ff);
      base_q = (SW+2)'({1'b0, cruise_spd}) <<< FRAC_BITS;
      prod = '0;
      ctrl = (acc_ff > LIMC) ? LIMC : ((acc_ff < -LIMC) ? -LIMC : acc_ff);
      lq = base_q - (SW+2)'(ctrl);
      rq = base_q + (SW+2)'(ctrl);
      unique case (step_ff)
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            quo_in = {quo_ff[NW-2:0], 1'b0};
            if (rtry >= {1'b0, cnt_ff}) begin
               rem_in = 3'(rtry - {1'b0, cnt_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = rtry[2:0];
            end
            dcnt_in = dcnt_ff - DW'(1);
            if (dcnt_ff == DW'(0)) step_in = S_SUM;
         end
         S_SUM: begin
            err_in = neg_ff ? -EW'(quo_ff) : EW'(quo_ff);
            step_in = S_KP;
         end
         S_KP: begin
            if (esum_raw > (SW+1)'(LIM)) esum_in = LIM;
            else if (esum_raw < -(SW+1)'(LIM)) esum_in = -LIM;
            else esum_in = SW'(esum_raw);
            prod = CW'(err_ff) * CW'($signed({1'b0, kp_gain}));
            acc_in = prod;
            step_in = S_KI;
         end
         S_KI: begin
            prod = CW'(esum_ff) * CW'($signed({1'b0, ki_gain}));
            acc_in = acc_ff + prod;
            step_in = S_KD;
         end
         S_KD: begin
            prod = CW'(derr) * CW'($signed({1'b0, kd_gain}));
            acc_in = acc_ff + prod;
            step_in = S_OUT;
         end
         S_OUT: begin
            pl_in = to_spd(lq);
            pr_in = to_spd(rq);
            prev_in = err_ff;
            step_in = S_FIN;
         end
         S_FIN: ;
         default: step_in = S_FIN;
      endcase
      if (cmd.pid_start) begin
         step_in = S_DIV;
         dcnt_in = DW'(NW - 1);
         quo_in = NW'(wmag) << FRAC_BITS;
         rem_in = 3'd0;
         cnt_in = cnt;
         neg_in = wsum[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_FIN;
         prev_ff <= '0;
         esum_ff <= '0;
      end else begin
         if (cmd.pid_step || cmd.pid_start) step_ff <= step_in;
         if (cmd.pid_step) begin
            prev_ff <= prev_in;
            esum_ff <= esum_in;
         end
      end
      if (cmd.pid_step || cmd.pid_start) begin
         dcnt_ff <= dcnt_in; quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
         neg_ff <= neg_in; err_ff <= err_in; acc_ff <= acc_in;
         pl_ff <= pl_in; pr_ff <= pr_in;
      end
   end

   assign stat.pid_done = (step_ff == S_FIN);
   assign stat.no_line  = (cnt == 3'd0);
   assign pid_left  = pl_ff;
   assign pid_right = pr_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lfpd_ctrl.sv -----
// lfpd_ctrl: mode sequencer, handshake control and result emission
// depends on lfpd_pkg; drives lfpd_dpath by command signals
`timescale 1ns / 1ps
`default_nettype none

module lfpd_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  wire  [4:0]            line_bits,
   input  wire                   dist_ok,
   input  wire  [9:0]            left_cm,
   input  wire  [9:0]            front_cm,
   input  wire  [9:0]            right_cm,
   input  wire  [31:0]           now_us,
   input  wire  [9:0]            front_limit_cm,
   input  wire  [9:0]            side_limit_cm,
   input  wire  [23:0]           turn_time_us,
   input  wire  [6:0]            detour_spd,
   output lfpd_pkg::cmd_type     cmd,
   input  wire lfpd_pkg::stat_type stat,
   input  wire  signed [7:0]     pid_left,
   input  wire  signed [7:0]     pid_right,
   output logic                  out_valid,
   input  wire                   out_ready,
   output lfpd_pkg::res_type     out_res,
   output logic [3:0]            out_mode,
   output logic                  out_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PID  = 2'd1;
   localparam logic [1:0] ST_OUT0 = 2'd2;
   localparam logic [1:0] ST_OUT1 = 2'd3;

   logic [1:0] st_ff, st_in;
   logic [3:0] mode_ff, mode_in;
   logic turn_ff, turn_in;
   logic [31:0] tbeg_ff, tbeg_in;
   logic pidres_ff, pidres_in;
   lfpd_pkg::res_type r0_ff, r0_in, r1_ff, r1_in;
   logic two_ff, two_in;

   logic near_f, near_l, near_r, tdone, take;
   logic signed [7:0] avs;
   lfpd_pkg::res_type stop_r;

   assign near_f = dist_ok && front_cm != 10'd0 && front_cm < front_limit_cm;
   assign near_l = dist_ok && left_cm != 10'd0 && left_cm < side_limit_cm;
   assign near_r = dist_ok && right_cm != 10'd0 && right_cm < side_limit_cm;
   assign tdone = (now_us - tbeg_ff) >= {8'd0, turn_time_us};
   assign avs = (detour_spd > 7'd100) ? 8'sd100 : $signed({1'b0, detour_spd});
   assign take = in_valid && in_ready;
   assign stop_r = '{drive: 1'b1, spd_l: 8'sd0, spd_r: 8'sd0,
                     hold_us: lfpd_pkg::STOP_HOLD};

   always_comb begin
      st_in = st_ff; mode_in = mode_ff; turn_in = turn_ff; tbeg_in = tbeg_ff;
      pidres_in = 1'b0; r0_in = r0_ff; r1_in = r1_ff; two_in = 1'b0;
      cmd = '0;
      unique case (st_ff)
         ST_IDLE: if (take) begin
            // decode one step of the mode sequence
            cmd.load = 1'b1;
            unique case (mode_ff) inside
               lfpd_pkg::MODE_FOLLOW: begin
                  if (near_f) begin
                     r0_in = stop_r; mode_in = lfpd_pkg::MODE_STOPPING;
                     st_in = ST_OUT0;
                  end else if (!stat.no_line) begin
                     cmd.pid_start = 1'b1; st_in = ST_PID;
                  end
               end
               lfpd_pkg::MODE_STOPPING: begin
                  r0_in = '{drive: 1'b0, spd_l: 8'sd0, spd_r: 8'sd0,
                            hold_us: lfpd_pkg::PAUSE_HOLD};
                  turn_in = 1'b0; mode_in = lfpd_pkg::MODE_TURN_R; st_in = ST_OUT0;
               end
               lfpd_pkg::MODE_TURN_R, lfpd_pkg::MODE_ALIGN, lfpd_pkg::MODE_TURN_L: begin
                  if (!turn_ff) begin
                     tbeg_in = now_us; turn_in = 1'b1;
                     r0_in.drive = 1'b1; r0_in.hold_us = '0;
                     r0_in.spd_l = (mode_ff == lfpd_pkg::MODE_TURN_R) ?
                        lfpd_pkg::TURN_SPD : -lfpd_pkg::TURN_SPD;
                     r0_in.spd_r = -r0_in.spd_l;
                     st_in = ST_OUT0;
                  end else if (tdone) begin
                     r0_in = stop_r; st_in = ST_OUT0;
                     if (mode_ff == lfpd_pkg::MODE_TURN_R) begin
                        turn_in = 1'b0; mode_in = lfpd_pkg::MODE_CHECK_R;
                     end else if (mode_ff == lfpd_pkg::MODE_ALIGN) begin
                        turn_in = 1'b0; mode_in = lfpd_pkg::MODE_FWD;
                     end else begin
                        mode_in = lfpd_pkg::MODE_FWD_MORE;
                     end
                  end
               end
               lfpd_pkg::MODE_CHECK_R:
                  mode_in = near_r ? lfpd_pkg::MODE_TURN_L : lfpd_pkg::MODE_FWD_SH;
               lfpd_pkg::MODE_CHECK_L: begin
                  if (!near_l) turn_in = 1'b0;
                  mode_in = lfpd_pkg::MODE_ALIGN;
               end
               lfpd_pkg::MODE_FWD_SH, lfpd_pkg::MODE_FWD, lfpd_pkg::MODE_FWD_MORE: begin
                  r0_in = '{drive: 1'b1, spd_l: avs, spd_r: avs,
                            hold_us: lfpd_pkg::SHORT_HOLD};
                  r1_in = stop_r; two_in = 1'b1; st_in = ST_OUT0;
                  if (mode_ff == lfpd_pkg::MODE_FWD_SH) begin
                     mode_in = lfpd_pkg::MODE_CHECK_L;
                  end else if (mode_ff == lfpd_pkg::MODE_FWD) begin
                     r0_in.hold_us = lfpd_pkg::FWD_HOLD;
                     if (!near_l) begin
                        turn_in = 1'b0; mode_in = lfpd_pkg::MODE_TURN_L;
                     end else mode_in = lfpd_pkg::MODE_FOLLOW;
                  end else begin
                     r0_in.hold_us = lfpd_pkg::MORE_HOLD;
                     if (!near_l) turn_in = 1'b0;
                     mode_in = lfpd_pkg::MODE_FOLLOW;
                  end
               end
               lfpd_pkg::MODE_FIND: begin
                  if (line_bits != 5'd0) mode_in = lfpd_pkg::MODE_FOLLOW;
                  else begin
                     r0_in = '{drive: 1'b1, spd_l: -lfpd_pkg::FIND_SPD,
                               spd_r: lfpd_pkg::FIND_SPD, hold_us: 21'd0};
                     st_in = ST_OUT0;
                  end
               end
               default: mode_in = lfpd_pkg::MODE_FOLLOW;
            endcase
         end
         ST_PID: begin
            // run the datapath until its sequence is done
            cmd.pid_step = 1'b1;
            pidres_in = 1'b1;
            if (stat.pid_done) begin
               cmd.pid_step = 1'b0;
               r0_in = '{drive: 1'b1, spd_l: pid_left, spd_r: pid_right,
                         hold_us: 21'd0};
               st_in = ST_OUT0;
            end
         end
         ST_OUT0: begin
            two_in = two_ff;
            if (out_ready) st_in = two_ff ? ST_OUT1 : ST_IDLE;
         end
         ST_OUT1: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; mode_ff <= lfpd_pkg::MODE_FOLLOW;
         turn_ff <= 1'b0; tbeg_ff <= '0; two_ff <= 1'b0; pidres_ff <= 1'b0;
      end else begin
         st_ff <= st_in; mode_ff <= mode_in; turn_ff <= turn_in;
         tbeg_ff <= tbeg_in; two_ff <= two_in; pidres_ff <= pidres_in;
      end
      r0_ff <= r0_in;
      r1_ff <= r1_in;
   end

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT0) || (st_ff == ST_OUT1);
   assign out_res   = (st_ff == ST_OUT1) ? r1_ff : r0_ff;
   assign out_mode  = mode_ff;
   assign out_last  = (st_ff == ST_OUT1) || !two_ff || pidres_ff;

endmodule

`default_nettype wire

// ----- rtl/core/line_follow_pid_with_obstacle_detour_unit.sv -----
// line_follow_pid_with_obstacle_detour_unit: top level of the line follower
// depends on lfpd_pkg, lfpd_ctrl and lfpd_dpath
//
//  channel   dir  handshake            payload
//  req       in   req_tvalid/tready    tdata: line, ok, left, front, right, now
//  rsp       out  rsp_tvalid/tready    tdata: drive,l,r,hold,mode; tlast
//  csr       in   csr_we               csr_index, csr_wdata
//
// a follow step with line passes through the accept state, the serial division
// by sensor count, the error, the three gain products in turn and the speeds,
// then loads the result and hands it over
// detour steps go from acceptance straight to their results; one item at a time
// reset clears mode, turn and pid state; results wait in registers while
// rsp_tready is low, and req_tready is low until the last result is taken
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_with_obstacle_detour_unit #(
   parameter int FRAC_BITS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,  // line_bits, dist_ok, left_cm, front_cm, right_cm, now_us
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,  // drive, spd_l, spd_r, hold_us, mode_now
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [23:0] csr_wdata
);

   logic [7:0] kp_ff, ki_ff, kd_ff;
   logic [6:0] base_ff, avoid_ff;
   logic [9:0] front_ff, side_ff;
   logic [23:0] turn_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= 8'd50; ki_ff <= 8'd1; kd_ff <= 8'd1; base_ff <= 7'd60;
         front_ff <= 10'd30; side_ff <= 10'd25; turn_ff <= 24'd1500000;
         avoid_ff <= 7'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            lfpd_pkg::REG_KP:    kp_ff <= csr_wdata[7:0];
            lfpd_pkg::REG_KI:    ki_ff <= csr_wdata[7:0];
            lfpd_pkg::REG_KD:    kd_ff <= csr_wdata[7:0];
            lfpd_pkg::REG_BASE:  base_ff <= csr_wdata[6:0];
            lfpd_pkg::REG_FRONT: front_ff <= csr_wdata[9:0];
            lfpd_pkg::REG_SIDE:  side_ff <= csr_wdata[9:0];
            lfpd_pkg::REG_TURN:  turn_ff <= csr_wdata[23:0];
            lfpd_pkg::REG_AVOID: avoid_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   lfpd_pkg::cmd_type cmd;
   lfpd_pkg::stat_type stat;
   lfpd_pkg::res_type res;
   logic signed [7:0] pid_left, pid_right;
   logic [3:0] mode_now;

   lfpd_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock, .reset, .cmd, .stat,
      .line_bits(req_tdata[4:0]), .kp_gain(kp_ff), .ki_gain(ki_ff), .kd_gain(kd_ff),
      .cruise_spd(base_ff), .pid_left, .pid_right
   );

   lfpd_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .line_bits(req_tdata[4:0]), .dist_ok(req_tdata[5]), .left_cm(req_tdata[15:6]),
      .front_cm(req_tdata[25:16]), .right_cm(req_tdata[35:26]),
      .now_us(req_tdata[67:36]), .front_limit_cm(front_ff), .side_limit_cm(side_ff),
      .turn_time_us(turn_ff), .detour_spd(avoid_ff), .cmd, .stat, .pid_left,
      .pid_right, .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res),
      .out_mode(mode_now), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {6'd0, mode_now, res.hold_us, res.spd_r, res.spd_l,
                       res.drive};

   // no new item while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready during result");
   // a result held under stall keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed under stall");
   // left speed stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[8:1]) <= 8'sd100 &&
                      $signed(rsp_tdata[8:1]) >= -8'sd100))
      else $error("speed out of range");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for the line follow pid detour unit
// depends on lfpd_pkg and line_follow_pid_with_obstacle_detour_unit
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int CYC_LIMIT = 600000;
   localparam int SETTLE    = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // line_bits, dist_ok, left_cm, front_cm, right_cm, now_us
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // drive, spd_l, spd_r, hold_us, mode_now
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   line_follow_pid_with_obstacle_detour_unit uut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata
   );

   typedef struct {
      logic        drive;
      logic [7:0]  lspd;
      logic [7:0]  rspd;
      logic [20:0] hold;
      logic [3:0]  mode;
      logic        last;
   } exp_type;

   exp_type  cmd_q[$];
   int       err_count = 0;
   int       cycles = 0;

   // predicted configuration and state
   int unsigned kp, ki, kd, base_spd, front_lim, side_lim, turn_us, avoid_spd;
   logic [3:0]  mode_p;
   bit          turning;
   logic [31:0] turn_start;
   longint      last_err, err_acc;
   logic [31:0] clk_us;   // stimulus time base

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls: mostly short, a few long, stretches of none
   initial begin
      int n;
      forever begin
         @(posedge clock);
         n = $urandom_range(0, 99);
         if (n < 50) rsp_tready <= 1'b1;
         else if (n < 90) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (n < 95) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      err_count++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
   endtask

   // result checker
   always @(posedge clock) begin
      exp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cmd_q.size() == 0) report("unexpected item", 0, 0);
         else begin
            e = cmd_q.pop_front();
            if (rsp_tdata[0] !== e.drive) report("drive", rsp_tdata[0], e.drive);
            if (rsp_tdata[8:1] !== e.lspd)
               report("left speed", $signed(rsp_tdata[8:1]), $signed(e.lspd));
            if (rsp_tdata[16:9] !== e.rspd)
               report("right speed", $signed(rsp_tdata[16:9]), $signed(e.rspd));
            if (rsp_tdata[37:17] !== e.hold) report("hold_us", rsp_tdata[37:17], e.hold);
            if (rsp_tdata[41:38] !== e.mode) report("mode_now", rsp_tdata[41:38], e.mode);
            if (rsp_tlast !== e.last) report("last_of_step", rsp_tlast, e.last);
         end
      end
   end

   function automatic longint sat100(input longint v);
      if (v > 100) return 100;
      if (v < -100) return -100;
      return v;
   endfunction

   function automatic longint clamp_lim(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic bit is_near(input bit ok, input int unsigned d, input int unsigned lim);
      return ok && d > 0 && d < lim;
   endfunction

   function automatic void add(ref exp_type outs[$], input bit drv, input longint l,
                               input longint r, input logic [20:0] hold);
      exp_type e;
      e.drive = drv;
      e.lspd = 8'(sat100(l));
      e.rspd = 8'(sat100(r));
      e.hold = hold;
      e.mode = '0;
      e.last = 1'b0;
      outs.push_back(e);
   endfunction

   // timed ninety degree turn
   function automatic void timed(ref exp_type outs[$], input logic [31:0] now,
                                 input longint l, input longint r, output bit done);
      logic [31:0] dt;
      done = 0;
      dt = now - turn_start;
      if (!turning) begin
         turn_start = now;
         turning = 1;
         add(outs, 1'b1, l, r, 21'd0);
      end else if (dt >= turn_us) begin
         done = 1;
         add(outs, 1'b1, 0, 0, lfpd_pkg::STOP_HOLD);
      end
   endfunction

   // motor command predictor: one control step, returns commands in order
   function automatic void drive_step(input logic [71:0] d, ref exp_type outs[$]);
      logic [4:0]  bits = d[4:0];
      bit          ok = d[5];
      int unsigned lcm = 32'(d[15:6]);
      int unsigned fcm = 32'(d[25:16]);
      int unsigned rcm = 32'(d[35:26]);
      logic [31:0] now = d[67:36];
      longint      lim = 100 <<< 8;
      longint      wsum, cnt, err, c, bq;
      bit          done;
      outs.delete();
      done = 0;
      case (mode_p)
         lfpd_pkg::MODE_FOLLOW: begin
            if (is_near(ok, fcm, front_lim)) begin
               add(outs, 1'b1, 0, 0, lfpd_pkg::STOP_HOLD);
               mode_p = lfpd_pkg::MODE_STOPPING;
            end else begin
               wsum = 0; cnt = 0;
               if (bits[0]) begin wsum -= 3; cnt++; end
               if (bits[1]) begin wsum -= 2; cnt++; end
               if (bits[2]) cnt++;
               if (bits[3]) begin wsum += 2; cnt++; end
               if (bits[4]) begin wsum += 3; cnt++; end
               if (cnt != 0) begin
                  err = (wsum * 256) / cnt;
                  err_acc = clamp_lim(err_acc + err, lim);
                  c = clamp_lim(kp * err + ki * err_acc + kd * (err - last_err), lim);
                  bq = longint'(base_spd) * 256;
                  add(outs, 1'b1, (bq - c) / 256, (bq + c) / 256, 21'd0);
                  last_err = err;
               end
            end
         end
         lfpd_pkg::MODE_STOPPING: begin
            add(outs, 1'b0, 0, 0, lfpd_pkg::PAUSE_HOLD);
            turning = 0;
            mode_p = lfpd_pkg::MODE_TURN_R;
         end
         lfpd_pkg::MODE_TURN_R: begin
            timed(outs, now, 15, -15, done);
            if (done) begin turning = 0; mode_p = lfpd_pkg::MODE_CHECK_R; end
         end
         lfpd_pkg::MODE_CHECK_R:
            mode_p = is_near(ok, rcm, side_lim) ? lfpd_pkg::MODE_TURN_L
                                                : lfpd_pkg::MODE_FWD_SH;
         lfpd_pkg::MODE_FWD_SH: begin
            add(outs, 1'b1, avoid_spd, avoid_spd, lfpd_pkg::SHORT_HOLD);
            add(outs, 1'b1, 0, 0, lfpd_pkg::STOP_HOLD);
            mode_p = lfpd_pkg::MODE_CHECK_L;
         end
         lfpd_pkg::MODE_CHECK_L: begin
            if (!is_near(ok, lcm, side_lim)) turning = 0;
            mode_p = lfpd_pkg::MODE_ALIGN;
         end
         lfpd_pkg::MODE_ALIGN: begin
            timed(outs, now, -15, 15, done);
            if (done) begin turning = 0; mode_p = lfpd_pkg::MODE_FWD; end
         end
         lfpd_pkg::MODE_FWD: begin
            add(outs, 1'b1, avoid_spd, avoid_spd, lfpd_pkg::FWD_HOLD);
            add(outs, 1'b1, 0, 0, lfpd_pkg::STOP_HOLD);
            if (!is_near(ok, lcm, side_lim)) begin
               turning = 0; mode_p = lfpd_pkg::MODE_TURN_L;
            end else mode_p = lfpd_pkg::MODE_FOLLOW;
         end
         lfpd_pkg::MODE_TURN_L: begin
            timed(outs, now, -15, 15, done);
            if (done) mode_p = lfpd_pkg::MODE_FWD_MORE;
         end
         lfpd_pkg::MODE_FWD_MORE: begin
            add(outs, 1'b1, avoid_spd, avoid_spd, lfpd_pkg::MORE_HOLD);
            add(outs, 1'b1, 0, 0, lfpd_pkg::STOP_HOLD);
            if (!is_near(ok, lcm, side_lim)) turning = 0;
            mode_p = lfpd_pkg::MODE_FOLLOW;
         end
         lfpd_pkg::MODE_FIND: begin
            if (bits != 0) mode_p = lfpd_pkg::MODE_FOLLOW;
            else add(outs, 1'b1, -7, 7, 21'd0);
         end
         default: mode_p = lfpd_pkg::MODE_FOLLOW;
      endcase
      foreach (outs[i]) begin
         outs[i].mode = mode_p;
         outs[i].last = (i == outs.size() - 1);
      end
   endfunction

   // send one item, predicting its commands on acceptance
   task automatic send_step(input logic [4:0] bits, input bit ok, input int unsigned lcm,
                            input int unsigned fcm, input int unsigned rcm,
                            input logic [31:0] now);
      exp_type outs[$];
      int n, gap;
      n = $urandom_range(0, 99);
      gap = (n < 55) ? 0 : (n < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, now, rcm[9:0], fcm[9:0], lcm[9:0], ok, bits};
      do @(posedge clock); while (!req_tready);
      drive_step({4'b0, now, rcm[9:0], fcm[9:0], lcm[9:0], ok, bits}, outs);
      foreach (outs[i]) cmd_q.push_back(outs[i]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (cmd_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register write; the caller drops csr_we after the last one
   task automatic write_reg(input logic [2:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[23:0];
      @(posedge clock);
      case (idx)
         lfpd_pkg::REG_KP:    kp = val & 8'hff;
         lfpd_pkg::REG_KI:    ki = val & 8'hff;
         lfpd_pkg::REG_KD:    kd = val & 8'hff;
         lfpd_pkg::REG_BASE:  base_spd = val & 7'h7f;
         lfpd_pkg::REG_FRONT: front_lim = val & 10'h3ff;
         lfpd_pkg::REG_SIDE:  side_lim = val & 10'h3ff;
         lfpd_pkg::REG_TURN:  turn_us = val & 24'hffffff;
         lfpd_pkg::REG_AVOID: avoid_spd = val & 7'h7f;
         default: ;
      endcase
   endtask

   task automatic set_all(input int unsigned p, input int unsigned i, input int unsigned dd,
                          input int unsigned b, input int unsigned f, input int unsigned s,
                          input int unsigned t, input int unsigned a);
      wait_idle();
      write_reg(lfpd_pkg::REG_KP, p);    write_reg(lfpd_pkg::REG_KI, i);
      write_reg(lfpd_pkg::REG_KD, dd);   write_reg(lfpd_pkg::REG_BASE, b);
      write_reg(lfpd_pkg::REG_FRONT, f); write_reg(lfpd_pkg::REG_SIDE, s);
      write_reg(lfpd_pkg::REG_TURN, t);  write_reg(lfpd_pkg::REG_AVOID, a);
      csr_we <= 1'b0;
   endtask

   // line patterns and the obstacle qualifiers in follow mode
   task automatic test_follow();
      logic [4:0] pats[10] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd24, 5'd4, 5'd2, 5'd17, 5'd6};
      foreach (pats[i]) send_step(pats[i], 1'b1, 500, 500, 500, clk_us);
      send_step(5'd4, 1'b0, 0, 5, 0, clk_us);       // near front but echo invalid
      send_step(5'd8, 1'b1, 1023, 0, 1023, clk_us); // no echo
   endtask

   // full detour with the right and left paths clear or blocked as given
   task automatic test_detour(input bit right_blocked, input bit left_blocked);
      int unsigned rc, lc;
      rc = right_blocked ? 5 : 200;
      lc = left_blocked ? 5 : 200;
      send_step(5'd4, 1'b1, lc, 10, rc, clk_us);   // obstacle
      send_step(5'd4, 1'b1, lc, 10, rc, clk_us);   // pause
      repeat (7) begin
         send_step(5'd0, 1'b1, lc, 10, rc, clk_us);
         clk_us += turn_us / 2 + 1;
         send_step(5'd0, 1'b1, lc, 10, rc, clk_us); // turn in progress or done
         clk_us += turn_us + 3;
      end
   endtask

   // random item shaped by the predicted mode
   task automatic rand_step();
      int n;
      int unsigned f, l, r;
      bit ok;
      n = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       clk_us = $urandom;
         1, 2, 3: clk_us += turn_us + $urandom_range(0, 2000);
         default: clk_us += $urandom_range(0, turn_us / 3 + 1);
      endcase
      ok = ($urandom_range(0, 9) != 0);
      if (mode_p == lfpd_pkg::MODE_FOLLOW && n < 15 && front_lim > 1)
         f = $urandom_range(1, front_lim - 1);
      else if (n < 30) f = $urandom_range(0, 1023);
      else f = (front_lim > 1000) ? 0 : $urandom_range(front_lim, 1023);
      l = $urandom_range(0, 1) ? $urandom_range(0, side_lim + 2) : $urandom_range(0, 1023);
      r = $urandom_range(0, 1) ? $urandom_range(0, side_lim + 2) : $urandom_range(0, 1023);
      send_step(($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom), ok, l, f, r, clk_us);
   endtask

   task automatic test_random(input int count);
      repeat (count) rand_step();
   endtask

   initial begin
      kp = 50; ki = 1; kd = 1; base_spd = 60; front_lim = 30; side_lim = 25;
      turn_us = 1500000; avoid_spd = 50;
      mode_p = lfpd_pkg::MODE_FOLLOW; turning = 0; turn_start = '0;
      last_err = 0; err_acc = 0;
      clk_us = 32'd1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_follow();
      test_detour(0, 0);
      test_detour(0, 1);
      test_detour(1, 0);
      // extremes: full gains, out-of-range speeds, longest turn
      set_all(255, 255, 255, 127, 1023, 1023, 24'hffffff, 127);
      test_follow();
      test_detour(0, 1);
      test_random(80);
      // zero gains and zero turn time
      set_all(0, 0, 0, 0, 1023, 0, 0, 0);
      test_random(100);
      set_all(50, 1, 1, 60, 30, 25, 1500000, 50);
      test_random(100);
      set_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 100), $urandom_range(0, 300), $urandom_range(0, 300),
              $urandom_range(0, 4000), $urandom_range(0, 100));
      test_random(100);
      set_all(100, 255, 3, 100, 0, 1023, 1, 100);
      test_random(30);

      wait_idle();
      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_dpath.sv
rtl/core/lfpd_ctrl.sv
rtl/core/line_follow_pid_with_obstacle_detour_unit.sv
tb/sv/testbench.sv
